/* hw/rtl/bsap_pkg.sv */
package bsap_pkg;

  // Window length of the moving average; must be a power of two.
  localparam int HISTORY_DEPTH = 8;
  localparam int DEPTH_LOG2    = $clog2(HISTORY_DEPTH);
  localparam int RUN_W         = $clog2(HISTORY_DEPTH + 1);

  localparam int POS_W   = 16;
  localparam int TIME_W  = 48;
  localparam int SPEED_W = 16;
  localparam int SUM_W   = SPEED_W + DEPTH_LOG2;

  // Squared distance, fixed-point root and the scaled dividend.
  localparam int D2_W     = 2 * POS_W + 1;
  localparam int FRAC_W   = 8;
  localparam int DIST_W   = (D2_W + 2 * FRAC_W + 1) / 2;
  localparam int RAD_W    = 2 * DIST_W;
  localparam int REM_W    = DIST_W + 3;
  localparam int SQ_CNT_W = $clog2(DIST_W);

  localparam int US_W             = 20;
  localparam logic [US_W-1:0] US_PER_S = 20'd1000000;
  localparam int MUL_W            = DIST_W + US_W;
  localparam int DIVD_W           = MUL_W - FRAC_W;
  localparam int DV_CNT_W         = $clog2(SPEED_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SQX,
    S_SQY,
    S_SQRT_GO,
    S_SQRT,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_WIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic               push;
    logic               valid;
    logic               playing;
    logic [SPEED_W-1:0] speed;
  } win_upd_t;

endpackage

/* hw/rtl/bsap_sqrt.sv */
module bsap_sqrt
  import bsap_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  logic                busy;
  logic [RAD_W-1:0]    rad_sr;
  logic [REM_W-1:0]    rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fits;

  // One result bit per cycle: two radicand bits enter the partial remainder.
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad_sr[RAD_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        rad_sr <= radicand;
        rem    <= '0;
        root   <= '0;
        cnt    <= '0;
      end else if (busy) begin
        rad_sr <= {rad_sr[RAD_W-3:0], 2'b00};
        rem    <= fits ? rem_sh - trial : rem_sh;
        root   <= {root[DIST_W-2:0], fits};
        cnt    <= cnt + 1'b1;
        if (cnt == SQ_CNT_W'(DIST_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/bsap_div.sv */
module bsap_div
  import bsap_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIVD_W-1:0]  dividend,
  input  logic [TIME_W-1:0]  divisor,
  output logic               done,
  output logic [SPEED_W-1:0] quotient
);

  localparam int HI_W = DIVD_W - SPEED_W;

  logic                busy;
  logic [TIME_W-1:0]   rem;
  logic [SPEED_W-1:0]  lo_sr;
  logic [DV_CNT_W-1:0] cnt;
  logic [TIME_W:0]     rem_sh;
  logic                fits;
  logic                ovf;

  always_comb begin
    rem_sh = {rem, lo_sr[SPEED_W-1]};
    fits   = rem_sh >= {1'b0, divisor};
    // A quotient that needs more than the speed width saturates at once.
    ovf    = TIME_W'(dividend[DIVD_W-1:SPEED_W]) >= divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (ovf) begin
          quotient <= '1;
          done     <= 1'b1;
        end else begin
          busy     <= 1'b1;
          rem      <= TIME_W'(dividend[DIVD_W-1 -: HI_W]);
          lo_sr    <= dividend[SPEED_W-1:0];
          quotient <= '0;
          cnt      <= '0;
        end
      end else if (busy) begin
        rem      <= fits ? TIME_W'(rem_sh - {1'b0, divisor}) : rem_sh[TIME_W-1:0];
        lo_sr    <= {lo_sr[SPEED_W-2:0], 1'b0};
        quotient <= {quotient[SPEED_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == DV_CNT_W'(SPEED_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/bsap_window.sv */
module bsap_window
  import bsap_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  win_upd_t           upd,
  output logic [SPEED_W-1:0] peak
);

  logic [SPEED_W-1:0] window [HISTORY_DEPTH];
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_next;
  logic [RUN_W-1:0]   run;
  logic [RUN_W-1:0]   run_next;
  logic [SPEED_W-1:0] avg;
  logic [SPEED_W-1:0] peak_base;

  // The running sum drops the oldest entry as the newest enters. The run
  // counter holds how many of the newest entries are valid, so the window is
  // wholly valid when it reaches the depth.
  always_comb begin
    sum_next  = sum - SUM_W'(window[0]) + SUM_W'(upd.speed);
    if (!upd.valid) begin
      run_next = '0;
    end else if (run == RUN_W'(HISTORY_DEPTH)) begin
      run_next = run;
    end else begin
      run_next = run + 1'b1;
    end
    avg       = SPEED_W'(sum_next >> DEPTH_LOG2);
    peak_base = upd.playing ? peak : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        window[i] <= '0;
      end
      sum  <= '0;
      run  <= RUN_W'(HISTORY_DEPTH);
      peak <= '0;
    end else if (upd.push) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[HISTORY_DEPTH-1] <= upd.speed;
      sum <= sum_next;
      run <= run_next;
      if (run_next == RUN_W'(HISTORY_DEPTH) && avg > peak_base) begin
        peak <= avg;
      end else begin
        peak <= peak_base;
      end
    end
  end

endmodule

/* hw/rtl/ball_speed_average_peak_core.sv */
// Ball speed estimator with a peak hold on the moving-average speed. Each
// input item is one tracking frame; each produces exactly one result item
// with the instantaneous speed in mm/s (saturated, zero when not computable),
// its valid flag and the held peak of the fully valid window average. Items
// are handled one at a time: a frame whose speed can be computed passes
// through the 25-step bit-serial square root and the 16-step bit-serial
// divider, which saturates at once when the quotient is too large for the
// speed width. The next frame is taken while a result still waits in the
// output register; in_ready is high only between frames.
module ball_speed_average_peak_core
  import bsap_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     ball_present,
  input  logic signed [POS_W-1:0]  ball_x,
  input  logic signed [POS_W-1:0]  ball_y,
  input  logic        [TIME_W-1:0] sample_time,
  input  logic                     playing,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [SPEED_W-1:0] speed,
  output logic                     speed_valid,
  output logic        [SPEED_W-1:0] peak_speed
);

  state_t state;
  state_t state_next;

  logic [POS_W-1:0]   prev_x;
  logic [POS_W-1:0]   prev_y;
  logic [TIME_W-1:0]  prev_time;
  logic               first_frame;

  logic [POS_W-1:0]   cx;
  logic [POS_W-1:0]   cy;
  logic [TIME_W-1:0]  ct;
  logic               play;

  logic [POS_W-1:0]   ax;
  logic [POS_W-1:0]   ay;
  logic [TIME_W-1:0]  dt;
  logic               spd_ok;
  logic [D2_W-1:0]    d2;
  logic [DIST_W-1:0]  dist_q8;
  logic [DIVD_W-1:0]  dividend;
  logic [SPEED_W-1:0] speed_r;

  logic [POS_W:0]     dx_c;
  logic [POS_W:0]     dy_c;
  logic [POS_W-1:0]   ax_c;
  logic [POS_W-1:0]   ay_c;
  logic [TIME_W-1:0]  dt_c;
  logic               ok_c;
  logic [POS_W-1:0]   mul_a;
  logic [2*POS_W-1:0] sq;
  logic [MUL_W-1:0]   prod;

  logic               sqrt_done;
  logic [DIST_W-1:0]  root;
  logic               div_done;
  logic [SPEED_W-1:0] quotient;
  logic [SPEED_W-1:0] peak;
  logic               out_free;
  win_upd_t           win_upd;

  always_comb begin
    dx_c  = {cx[POS_W-1], cx} - {prev_x[POS_W-1], prev_x};
    dy_c  = {cy[POS_W-1], cy} - {prev_y[POS_W-1], prev_y};
    ax_c  = dx_c[POS_W] ? POS_W'(-dx_c) : dx_c[POS_W-1:0];
    ay_c  = dy_c[POS_W] ? POS_W'(-dy_c) : dy_c[POS_W-1:0];
    dt_c  = ct - prev_time;
    ok_c  = !first_frame && ct != '0 && prev_time != '0 && dt_c != '0;
    mul_a = (state == S_SQX) ? ax : ay;
    sq    = mul_a * mul_a;
    prod  = MUL_W'(dist_q8) * MUL_W'(US_PER_S);
    out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    win_upd.push     = 1'b0;
    win_upd.valid    = spd_ok;
    win_upd.playing  = play;
    win_upd.speed    = speed_r;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP:    state_next = ok_c ? S_SQX : S_WIN;
      S_SQX:     state_next = S_SQY;
      S_SQY:     state_next = S_SQRT_GO;
      S_SQRT_GO: state_next = S_SQRT;
      S_SQRT: begin
        if (sqrt_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL:     state_next = S_DIV_GO;
      S_DIV_GO:  state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        win_upd.push = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Stored previous sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_y      <= '0;
      prev_time   <= '0;
      first_frame <= 1'b1;
    end else if (state == S_PREP) begin
      prev_x      <= cx;
      prev_y      <= cy;
      prev_time   <= ct;
      first_frame <= 1'b0;
    end
  end

  // Per-frame working registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cx   <= ball_present ? ball_x : '0;
          cy   <= ball_present ? ball_y : '0;
          ct   <= ball_present ? sample_time : '0;
          play <= playing;
        end
      end
      S_PREP: begin
        ax      <= ax_c;
        ay      <= ay_c;
        dt      <= dt_c;
        spd_ok  <= ok_c;
        speed_r <= '0;
      end
      S_SQX: d2 <= D2_W'(sq);
      S_SQY: d2 <= d2 + D2_W'(sq);
      S_SQRT: begin
        if (sqrt_done) begin
          dist_q8 <= root;
        end
      end
      S_MUL: dividend <= prod[MUL_W-1:FRAC_W];
      S_DIV: begin
        if (div_done) begin
          speed_r <= quotient;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      speed       <= speed_r;
      speed_valid <= spd_ok;
      peak_speed  <= peak;
    end
  end

  bsap_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SQRT_GO),
    .radicand (RAD_W'({d2, {(2*FRAC_W){1'b0}}})),
    .done     (sqrt_done),
    .root     (root)
  );

  bsap_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIV_GO),
    .dividend (dividend),
    .divisor  (dt),
    .done     (div_done),
    .quotient (quotient)
  );

  bsap_window u_window (
    .clk  (clk),
    .rst  (rst),
    .upd  (win_upd),
    .peak (peak)
  );

endmodule

/* hw/rtl/bsap_checker.sv */
module bsap_checker
  import bsap_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      ball_present,
  input logic signed [POS_W-1:0]   ball_x,
  input logic signed [POS_W-1:0]   ball_y,
  input logic        [TIME_W-1:0]  sample_time,
  input logic                      playing,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic        [SPEED_W-1:0] speed,
  input logic                      speed_valid,
  input logic        [SPEED_W-1:0] peak_speed
);

  // A frame offered but not yet taken stays in place.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(ball_present) &&
      $stable(ball_x) && $stable(ball_y) && $stable(sample_time) && $stable(playing))
    else $error("frame changed while waiting");

  // A result held back by the consumer stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(speed) &&
      $stable(speed_valid) && $stable(peak_speed))
    else $error("result changed while stalled");

  // A speed that could not be computed is reported as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !speed_valid |-> speed == '0)
    else $error("invalid speed not zero");

  // Frames are handled one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Reset leaves no result pending and the block ready for a frame.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind ball_speed_average_peak_core bsap_checker u_bsap_checker (.*);

/* bench/ball_speed_average_peak_core_tb.sv */
module ball_speed_average_peak_core_tb
  import bsap_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_COUNT = 1000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int MAX_REPORTS = 40;
  localparam int PENDING_DEPTH = 64;

  typedef struct {
    logic                    present;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [TIME_W-1:0]       stamp;
    logic                    playing;
  } frame_t;

  typedef struct {
    logic [SPEED_W-1:0] speed;
    logic               ok;
    logic [SPEED_W-1:0] peak;
  } speed_result_t;

  // Tracks the estimator state frame by frame and holds the results still owed by the block.
  class speed_scoreboard;
    logic signed [POS_W-1:0] last_x = '0;
    logic signed [POS_W-1:0] last_y = '0;
    logic [TIME_W-1:0]       last_stamp = '0;
    bit                      no_history = 1'b1;
    logic [SPEED_W-1:0]      hist_speed[HISTORY_DEPTH];
    bit                      hist_ok[HISTORY_DEPTH];
    logic [SPEED_W-1:0]      peak = '0;
    speed_result_t           awaiting[PENDING_DEPTH];
    int head = 0;
    int tail = 0;
    int errors = 0;
    int frames = 0;
    int computed = 0;
    int saturated = 0;
    int full_windows = 0;
    int peak_clears = 0;

    function new();
      foreach (hist_speed[i]) begin
        hist_speed[i] = '0;
        hist_ok[i] = 1'b1;
      end
    endfunction

    static function longint unsigned root_of(longint unsigned n);
      longint unsigned root, cand;
      root = 0;
      // The argument stays below 2^50, so the root fits in 26 bits.
      for (int b = 25; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= n) root = cand;
      end
      return root;
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void note_frame(frame_t f);
      logic signed [POS_W-1:0] cur_x, cur_y;
      logic [TIME_W-1:0] cur_stamp, dt;
      longint dx, dy;
      longint unsigned d2, root_q8, quot, sum;
      speed_result_t r;
      bit all_ok;
      cur_x = f.present ? f.x : '0;
      cur_y = f.present ? f.y : '0;
      cur_stamp = f.present ? f.stamp : '0;
      r.speed = '0;
      r.ok = 1'b0;
      if (!f.playing) begin
        if (peak != 0) peak_clears++;
        peak = '0;
      end
      dt = cur_stamp - last_stamp;
      if (!no_history && cur_stamp != 0 && last_stamp != 0 && dt != 0) begin
        dx = longint'(cur_x) - longint'(last_x);
        dy = longint'(cur_y) - longint'(last_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        d2 = dx * dx + dy * dy;
        root_q8 = root_of(d2 << 16);
        quot = (root_q8 * 64'd1000000) / ({16'd0, dt} << 8);
        r.speed = (quot > 64'd65535) ? '1 : quot[SPEED_W-1:0];
        r.ok = 1'b1;
        computed++;
        if (quot > 64'd65535) saturated++;
      end
      no_history = 1'b0;
      last_x = cur_x;
      last_y = cur_y;
      last_stamp = cur_stamp;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_speed[i-1] = hist_speed[i];
        hist_ok[i-1] = hist_ok[i];
      end
      hist_speed[HISTORY_DEPTH-1] = r.speed;
      hist_ok[HISTORY_DEPTH-1] = r.ok;
      sum = 0;
      all_ok = 1'b1;
      foreach (hist_speed[i]) begin
        sum += hist_speed[i];
        all_ok &= hist_ok[i];
      end
      if (all_ok) begin
        full_windows++;
        if (sum / HISTORY_DEPTH > peak) peak = SPEED_W'(sum / HISTORY_DEPTH);
      end
      r.peak = peak;
      awaiting[tail % PENDING_DEPTH] = r;
      tail++;
      frames++;
    endfunction

    function void check_result(logic [SPEED_W-1:0] speed, logic ok, logic [SPEED_W-1:0] pk);
      speed_result_t want;
      if (tail == head) begin
        flag("unexpected result item, speed", 0, speed);
        return;
      end
      want = awaiting[head % PENDING_DEPTH];
      head++;
      if (ok !== want.ok) flag("speed_valid", want.ok, ok);
      if (speed !== want.speed) flag("speed", want.speed, speed);
      if (pk !== want.peak) flag("peak_speed", want.peak, pk);
    endfunction

    function int outstanding();
      return tail - head;
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     ball_present = 1'b0;
  logic signed [POS_W-1:0]  ball_x = '0;
  logic signed [POS_W-1:0]  ball_y = '0;
  logic [TIME_W-1:0]        sample_time = '0;
  logic                     playing = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [SPEED_W-1:0]       speed;
  logic                     speed_valid;
  logic [SPEED_W-1:0]       peak_speed;

  speed_scoreboard sb = new();

  int frames_sent = 0;
  int cycles = 0;
  int tx_quiet_left = 0;
  bit tx_quiet = 1'b0;
  int rx_quiet_left = 0;
  bit rx_quiet = 1'b0;
  logic signed [POS_W-1:0] track_x = '0;
  logic signed [POS_W-1:0] track_y = '0;
  logic [TIME_W-1:0] track_stamp = 48'd1;

  ball_speed_average_peak_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ball_present(ball_present),
    .ball_x      (ball_x),
    .ball_y      (ball_y),
    .sample_time (sample_time),
    .playing     (playing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .speed       (speed),
    .speed_valid (speed_valid),
    .peak_speed  (peak_speed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Results are checked before the same edge's input is noted, so a result
  // can never be matched against the frame accepted alongside it.
  always @(posedge clk) begin
    frame_t f;
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(speed, speed_valid, peak_speed);
      if (in_valid && in_ready) begin
        f.present = ball_present;
        f.x = ball_x;
        f.y = ball_y;
        f.stamp = sample_time;
        f.playing = playing;
        sb.note_frame(f);
      end
    end
  end

  function automatic logic [TIME_W-1:0] rand_stamp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_W-1:0];
  endfunction

  // Called just after a rising edge; returns just after the edge that took the item.
  task automatic send_frame(input bit present, input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y,
                            input logic [TIME_W-1:0] stamp, input bit play);
    int gap;
    if (tx_quiet_left == 0) begin
      tx_quiet = ($urandom_range(0, 2) == 0);
      tx_quiet_left = $urandom_range(10, 60);
    end
    tx_quiet_left--;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ball_present <= present;
    ball_x <= x;
    ball_y <= y;
    sample_time <= stamp;
    playing <= play;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  task automatic run_directed();
    send_frame(1, 0, 0, 48'd1000, 1);               // first frame after reset
    send_frame(1, -32768, -32768, 48'd2000, 1);
    send_frame(1, 32767, 32767, 48'd2001, 1);       // full-scale jump in 1 us saturates
    send_frame(1, 32767, 32767, 48'd2001, 1);       // no time elapsed
    send_frame(1, 100, 0, 48'd0, 1);                // zero timestamp
    send_frame(1, 200, 0, 48'd5000, 1);             // previous time was zero
    send_frame(0, -1, -1, '1, 1);                   // ball missing, fields ignored
    send_frame(1, 0, 0, '1, 1);
    send_frame(1, 3, 4, 48'd10, 1);                 // timestamp wraps past the top
    send_frame(1, 1000, -1000, 48'd5, 1);           // time runs backwards
    for (int i = 0; i < 10; i++)
      send_frame(1, 16'(100 + 50 * i), 16'(-7 * i), 48'(100000 + 10000 * i), 1);
    send_frame(1, 700, -70, 48'd200000, 0);         // play stop with a full valid window
    send_frame(0, 0, 0, 48'd0, 0);
    send_frame(1, -5, 9, 48'h8000_0000_0000, 1);
    track_x = -5;
    track_y = 9;
    track_stamp = 48'h8000_0000_0000;
  endtask

  // A run of well-formed frames from a moving ball, with the odd oddity mixed in.
  task automatic run_track();
    int len, sel;
    bit play;
    logic signed [POS_W-1:0] x, y;
    logic [TIME_W-1:0] stamp, dt;
    len = $urandom_range(9, 30);
    play = ($urandom_range(0, 6) != 0);
    stamp = ($urandom_range(0, 3) == 0) ? rand_stamp() : track_stamp;
    if ($urandom_range(0, 3) == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else begin
      x = track_x;
      y = track_y;
    end
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) dt = 0;
      else if (sel < 12) dt = 48'($urandom_range(1, 300));
      else if (sel < 15) dt = 48'($urandom_range(1000000, 50000000));
      else dt = 48'($urandom_range(8000, 40000));
      stamp = stamp + dt;
      if ($urandom_range(0, 19) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = x + 16'(int'($urandom_range(0, 800)) - 400);
        y = y + 16'(int'($urandom_range(0, 800)) - 400);
      end
      if ($urandom_range(0, 24) == 0) play = ~play;
      send_frame(1, x, y, stamp, play);
    end
    track_x = x;
    track_y = y;
    track_stamp = stamp;
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: send_frame(0, 16'($urandom), 16'($urandom), rand_stamp(),
                      1'($urandom_range(0, 1)));
        1: send_frame(1, 16'($urandom), 16'($urandom), '0, 1'($urandom_range(0, 1)));
        2: send_frame(1, track_x, track_y,
                      track_stamp - 48'($urandom_range(1, 100000)),
                      1'($urandom_range(0, 1)));
        default: send_frame(1, 16'($urandom), 16'($urandom), rand_stamp(),
                            1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (frames_sent < FRAME_COUNT) begin
      if ($urandom_range(0, 4) == 0) run_noise();
      else run_track();
    end
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d frames: %0d with a computable speed, %0d of those saturated.",
             sb.frames, sb.computed, sb.saturated);
    $display("The window was fully valid on %0d frames; play stops cleared the peak %0d times.",
             sb.full_windows, sb.peak_clears);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side. Twice in the run it holds off for a long stretch so that the
  // block fills up and has to refuse further frames.
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_quiet_left == 0) begin
        rx_quiet = ($urandom_range(0, 2) == 0);
        rx_quiet_left = $urandom_range(10, 60);
      end
      rx_quiet_left--;
      gap = rx_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken == 150 || taken == 600) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
    end
  end

endmodule
